// File: hw/rtl/clcd_pkg.sv
`default_nettype none
package clcd_pkg;

	localparam int PATTERN_RAM_SIZE = 64;
	localparam int LINE_SPAN        = 40;
	// second-line codes start at 0x40 and land right after the first line
	localparam int LINE2_OFFSET     = 24;

	localparam logic [7:0] SPACE_CHAR = 8'h20;

	localparam logic signed [7:0] SHIFT_LIMIT = 8'sd40;

	typedef enum logic [2:0] {
		OP_CMD    = 3'd0,
		OP_DATA   = 3'd1,
		OP_STATUS = 3'd2,
		OP_READ   = 3'd3,
		OP_BLINK  = 3'd4
	} op_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_FETCH,
		ST_EXEC
	} state_t;

	typedef struct packed {
		logic dsh;  // shift display on data write
		logic did;  // increment
		logic cbl;  // cursor blink
		logic con;  // cursor on
		logic don;  // display on
		logic cd;   // last shift moved display
		logic lr;   // shift right
		logic fnt;  // font
		logic nli;  // two lines
		logic dl;   // 8-bit bus
	} mode_t;

endpackage
`default_nettype wire

// File: hw/rtl/clcd_req_if.sv
`default_nettype none
interface clcd_req_if;
	logic       valid;
	logic       ready;
	logic [2:0] op;
	logic [7:0] value;

	modport source (output valid, output op, output value, input ready);
	modport sink   (input valid, input op, input value, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/clcd_rsp_if.sv
`default_nettype none
interface clcd_rsp_if;
	logic              valid;
	logic              ready;
	logic [7:0]        read_value;
	logic [6:0]        address;
	logic signed [6:0] display_shift;
	logic              cgram_selected;
	logic              display_enabled;
	logic              cursor_enabled;
	logic              blink_phase;
	logic              redraw;

	modport source (
		output valid, output read_value, output address, output display_shift,
		output cgram_selected, output display_enabled, output cursor_enabled,
		output blink_phase, output redraw, input ready
	);
	modport sink (
		input valid, input read_value, input address, input display_shift,
		input cgram_selected, input display_enabled, input cursor_enabled,
		input blink_phase, input redraw, output ready
	);
endinterface
`default_nettype wire

// File: hw/rtl/clcd_ram.sv
`default_nettype none
// Byte RAM with registered read. Per-entry valid bits make unwritten
// (or cleared) entries read as the fill byte.
module clcd_ram #(
	parameter int DEPTH = 80
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     clear,
	input  wire logic                     rd_en,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic [7:0]               wdata,
	input  wire logic [7:0]               fill,
	output      logic [7:0]               rdata
);
	logic [7:0]       mem [DEPTH];
	logic [DEPTH-1:0] valid_q;
	logic [7:0]       mem_rd_q;
	logic             hit_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		if (rd_en) begin
			mem_rd_q <= mem[addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			hit_q   <= 1'b0;
		end else begin
			if (clear) begin
				valid_q <= '0;
			end else if (we) begin
				valid_q[addr] <= 1'b1;
			end
			if (rd_en) begin
				hit_q <= valid_q[addr];
			end
		end
	end

	assign rdata = hit_q ? mem_rd_q : fill;

endmodule
`default_nettype wire

// File: hw/rtl/char_lcd_controller_interface_unit.sv
`default_nettype none
// Channel | Dir | Payload                                    | Handshake
// req     | in  | op[2:0], value[7:0]                        | valid/ready
// rsp     | out | read_value, address, display_shift, flags  | valid/ready
//
// Each request passes through three steps: accept, RAM fetch at the address counter,
// execute and write back. The next request waits until the previous one has
// executed; the registered display/pattern RAM read precedes the read-modify-write.
// Reset: async, active low; display RAM reads as spaces and pattern RAM as
// zero through valid bits, so no clearing pass. Clear display drops the
// display valid bits all together.
// A result waiting in the output register does not block acceptance; the
// execute step holds only if the previous result is still not taken.
module char_lcd_controller_interface_unit
	import clcd_pkg::*;
#(
	parameter int DISPLAY_RAM_SIZE = 80,
	parameter int BLINK_TICKS      = 4
) (
	input wire logic    clk,
	input wire logic    arst_n,
	clcd_req_if.sink    req,
	clcd_rsp_if.source  rsp
);
	localparam int DAW = $clog2(DISPLAY_RAM_SIZE);
	localparam int PAW = $clog2(PATTERN_RAM_SIZE);
	localparam int BCW = $clog2(BLINK_TICKS + 1);

	// ---------------- helpers ----------------
	function automatic logic [6:0] step_addr(input logic [6:0] ac, input logic pm,
			input logic up);
		logic [7:0] size;
		logic [7:0] inc;
		size = pm ? 8'(PATTERN_RAM_SIZE) : 8'(DISPLAY_RAM_SIZE);
		inc  = {1'b0, ac} + 8'd1;
		if (up) begin
			step_addr = (inc >= size) ? 7'd0 : inc[6:0];
		end else begin
			// decrement wraps to the top of the selected RAM
			step_addr = (ac == 7'd0 || {1'b0, ac} > size) ? 7'(size - 8'd1) : ac - 7'd1;
		end
	endfunction

	function automatic logic signed [6:0] shift_by(input logic signed [6:0] s,
			input logic right);
		logic signed [7:0] t;
		t = {s[6], s};
		t = right ? t + 8'sd1 : t - 8'sd1;
		if (t > SHIFT_LIMIT) begin
			t = t - SHIFT_LIMIT;
		end
		if (t < -SHIFT_LIMIT) begin
			t = t + SHIFT_LIMIT;
		end
		shift_by = t[6:0];
	endfunction

	// ---------------- state ----------------
	state_t            st_q, st_n;
	logic [6:0]        ac_q;
	logic              pm_q;
	mode_t             mode_q;
	logic              pend_q;
	logic [3:0]        hold_q;
	logic signed [6:0] sh_q;
	logic              bst_q;
	logic [BCW-1:0]    cnt_q;

	logic [2:0]        op_s1;
	logic [7:0]        value_s1;

	logic              out_valid_q;
	logic [7:0]        rv_q;
	logic [6:0]        addr_q;
	logic signed [6:0] shift_q;
	logic              pm_out_q;
	logic              don_q;
	logic              con_q;
	logic              blink_q;
	logic              redraw_q;

	// ---------------- sequencer ----------------
	logic in_ready;
	logic rd_en;
	logic exec_fire;

	always_comb begin
		st_n = st_q;
		unique case (st_q)
			ST_IDLE:  if (req.valid) st_n = ST_FETCH;
			ST_FETCH: st_n = ST_EXEC;
			ST_EXEC:  if (!out_valid_q || rsp.ready) st_n = ST_IDLE;
			default:  st_n = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready  = (st_q == ST_IDLE);
		rd_en     = (st_q == ST_FETCH);
		exec_fire = (st_q == ST_EXEC) && (!out_valid_q || rsp.ready);
	end

	assign req.ready = in_ready;

	// ---------------- memories ----------------
	logic       dram_in_range;
	logic       pram_in_range;
	logic [7:0] dram_rd;
	logic [7:0] pram_rd;
	logic       dwe;
	logic       pwe;
	logic       dclr;
	logic [7:0] byte_v;

	assign dram_in_range = {1'b0, ac_q} < 8'(DISPLAY_RAM_SIZE);
	assign pram_in_range = {1'b0, ac_q} < 8'(PATTERN_RAM_SIZE);

	clcd_ram #(.DEPTH(DISPLAY_RAM_SIZE)) u_dram (
		.clk    (clk),
		.arst_n (arst_n),
		.clear  (dclr && exec_fire),
		.rd_en  (rd_en),
		.we     (dwe && exec_fire),
		.addr   (ac_q[DAW-1:0]),
		.wdata  (byte_v),
		.fill   (SPACE_CHAR),
		.rdata  (dram_rd)
	);

	clcd_ram #(.DEPTH(PATTERN_RAM_SIZE)) u_pram (
		.clk    (clk),
		.arst_n (arst_n),
		.clear  (1'b0),
		.rd_en  (rd_en),
		.we     (pwe && exec_fire),
		.addr   (ac_q[PAW-1:0]),
		.wdata  (byte_v),
		.fill   (8'h00),
		.rdata  (pram_rd)
	);

	// ---------------- execute ----------------
	logic              is_cmd;
	logic              is_data;
	logic              full;
	logic [6:0]        dd_code;
	logic [6:0]        n_ac;
	logic              n_pm;
	mode_t             n_mode;
	logic              n_pend;
	logic [3:0]        n_hold;
	logic signed [6:0] n_sh;
	logic              n_bst;
	logic [BCW-1:0]    n_cnt;
	logic [7:0]        n_rv;
	logic              n_redraw;

	always_comb begin
		n_ac     = ac_q;
		n_pm     = pm_q;
		n_mode   = mode_q;
		n_pend   = pend_q;
		n_hold   = hold_q;
		n_sh     = sh_q;
		n_bst    = bst_q;
		n_cnt    = cnt_q;
		n_rv     = 8'h00;
		n_redraw = 1'b0;
		dwe      = 1'b0;
		pwe      = 1'b0;
		dclr     = 1'b0;
		dd_code  = 7'd0;

		// display off turns a data write into a command
		is_cmd  = (op_s1 == OP_CMD) || (op_s1 == OP_DATA && !mode_q.don);
		is_data = (op_s1 == OP_DATA) && mode_q.don;

		// byte assembly; 4-bit mode takes high nibble first
		if (mode_q.dl) begin
			byte_v = value_s1;
			full   = 1'b1;
		end else begin
			byte_v = {hold_q, value_s1[7:4]};
			full   = pend_q;
			if (is_cmd || is_data) begin
				n_pend = !pend_q;
				if (!pend_q) begin
					n_hold = value_s1[7:4];
				end
			end
		end

		if (is_cmd && full) begin
			priority if (byte_v[7]) begin
				dd_code = byte_v[6:0];
				n_ac = (dd_code < 7'(LINE_SPAN)) ? dd_code : dd_code - 7'(LINE2_OFFSET);
				if ({1'b0, n_ac} >= 8'(DISPLAY_RAM_SIZE)) begin
					n_ac = 7'd0;
				end
				n_pm = 1'b0;
			end else if (byte_v[6]) begin
				n_ac = {1'b0, byte_v[5:0]};
				n_pm = 1'b1;
			end else if (byte_v[5]) begin
				n_mode.dl  = byte_v[4];
				n_mode.nli = byte_v[3];
				n_mode.fnt = byte_v[2];
			end else if (byte_v[4]) begin
				n_mode.lr = byte_v[2];
				if (byte_v[3]) begin
					n_mode.cd = 1'b1;
					n_sh = shift_by(sh_q, byte_v[2]);
				end else begin
					n_mode.cd = 1'b0;
					n_ac = step_addr(ac_q, pm_q, byte_v[2]);
				end
				n_redraw = 1'b1;
			end else if (byte_v[3]) begin
				n_mode.don = byte_v[2];
				n_mode.con = byte_v[1];
				n_mode.cbl = byte_v[0];
				n_redraw   = 1'b1;
			end else if (byte_v[2]) begin
				n_mode.did = byte_v[1];
				n_mode.dsh = byte_v[0];
			end else if (byte_v[1]) begin
				// return home
				n_ac     = 7'd0;
				n_pm     = 1'b0;
				n_sh     = '0;
				n_redraw = 1'b1;
			end else if (byte_v[0]) begin
				// clear display
				dclr       = 1'b1;
				n_ac       = 7'd0;
				n_pm       = 1'b0;
				n_sh       = '0;
				n_mode.did = 1'b1;
				n_redraw   = 1'b1;
			end else begin
				// command zero: no effect
				n_redraw = 1'b0;
			end
		end

		if (is_data && full) begin
			if (pm_q) begin
				pwe = pram_in_range;
			end else begin
				dwe = dram_in_range;
				if (mode_q.dsh) begin
					n_sh = shift_by(sh_q, !mode_q.did);
				end
			end
			n_ac     = step_addr(ac_q, pm_q, mode_q.did);
			n_redraw = 1'b1;
		end

		unique case (op_t'(op_s1))
			OP_STATUS: n_rv = {1'b0, ac_q};
			OP_READ: begin
				if (pm_q) begin
					n_rv = pram_in_range ? pram_rd : 8'h00;
				end else begin
					n_rv = dram_in_range ? dram_rd : 8'h00;
				end
				n_ac = step_addr(ac_q, pm_q, mode_q.did);
			end
			OP_BLINK: begin
				if (mode_q.con && mode_q.cbl) begin
					if (cnt_q >= BCW'(BLINK_TICKS)) begin
						n_cnt    = '0;
						n_bst    = !bst_q;
						n_redraw = 1'b1;
					end else begin
						n_cnt = cnt_q + BCW'(1);
					end
				end else begin
					n_bst = 1'b0;
				end
			end
			OP_CMD, OP_DATA: n_rv = 8'h00;
			default: n_rv = 8'h00;  // unused codes: nothing changes
		endcase
	end

	// ---------------- registers ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q     <= ST_IDLE;
			ac_q     <= 7'd0;
			pm_q     <= 1'b0;
			mode_q   <= '{dl: 1'b1, did: 1'b1, default: 1'b0};
			pend_q   <= 1'b0;
			hold_q   <= 4'd0;
			sh_q     <= '0;
			bst_q    <= 1'b0;
			cnt_q    <= '0;
		end else begin
			st_q <= st_n;
			if (exec_fire) begin
				ac_q   <= n_ac;
				pm_q   <= n_pm;
				mode_q <= n_mode;
				pend_q <= n_pend;
				hold_q <= n_hold;
				sh_q   <= n_sh;
				bst_q  <= n_bst;
				cnt_q  <= n_cnt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && in_ready) begin
			op_s1    <= req.op;
			value_s1 <= req.value;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (exec_fire) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (exec_fire) begin
			rv_q     <= n_rv;
			addr_q   <= n_ac;
			shift_q  <= n_sh;
			pm_out_q <= n_pm;
			don_q    <= n_mode.don;
			con_q    <= n_mode.con;
			blink_q  <= n_bst;
			redraw_q <= n_redraw;
		end
	end

	assign rsp.valid           = out_valid_q;
	assign rsp.read_value      = rv_q;
	assign rsp.address         = addr_q;
	assign rsp.display_shift   = shift_q;
	assign rsp.cgram_selected  = pm_out_q;
	assign rsp.display_enabled = don_q;
	assign rsp.cursor_enabled  = con_q;
	assign rsp.blink_phase     = blink_q;
	assign rsp.redraw          = redraw_q;

endmodule
`default_nettype wire

// File: hw/rtl/clcd_checker.sv
`default_nettype none
module clcd_checker
	import clcd_pkg::*;
#(
	parameter int DISPLAY_RAM_SIZE = 80
) (
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              in_valid,
	input wire logic              in_ready,
	input wire logic              out_valid,
	input wire logic              out_ready,
	input wire logic [6:0]        address,
	input wire logic signed [6:0] display_shift,
	input wire logic              cgram_selected,
	input wire logic [7:0]        read_value
);
	// held result keeps its payload
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(address) && $stable(read_value))
		else $error("result dropped or changed while stalled");

	// one request in flight: busy right after an accept
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("request accepted while previous still executing");

	a_dram_addr: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !cgram_selected |-> {1'b0, address} < 8'(DISPLAY_RAM_SIZE))
		else $error("display address out of range");

	a_cgram_addr: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && cgram_selected |-> {1'b0, address} < 8'(PATTERN_RAM_SIZE))
		else $error("pattern address out of range");

	a_shift: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (display_shift <= 7'sd40) && (display_shift >= -7'sd40))
		else $error("display shift out of range");

endmodule

bind char_lcd_controller_interface_unit clcd_checker #(
	.DISPLAY_RAM_SIZE(DISPLAY_RAM_SIZE)
) u_clcd_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.in_valid       (req.valid),
	.in_ready       (req.ready),
	.out_valid      (rsp.valid),
	.out_ready      (rsp.ready),
	.address        (rsp.address),
	.display_shift  (rsp.display_shift),
	.cgram_selected (rsp.cgram_selected),
	.read_value     (rsp.read_value)
);
`default_nettype wire
